### hw/rtl/chta_pkg.sv
// shared types, constants and helpers for the clustered hash table
`default_nettype none
package chta_pkg;

  localparam int INDEX_BITS   = 16;
  localparam int CLUSTER_WAYS = 4;
  localparam int DATE_COUNT   = 16;
  localparam int VALUE_INF    = 30000;

  localparam int WAY_W      = (CLUSTER_WAYS > 1) ? $clog2(CLUSTER_WAYS) : 1;
  localparam int SLOT_COUNT = (1 << INDEX_BITS) + CLUSTER_WAYS - 1;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int DATE_W     = $clog2(DATE_COUNT);
  localparam int SCORE_W    = DATE_W + 10;
  localparam int USED_W     = 17;

  localparam logic [USED_W-1:0] USED_MAX = '1;
  localparam logic signed [7:0] DEPTH_NONE = -8'sd128;
  localparam logic signed [15:0] VAL_MIN = -16'(VALUE_INF);
  localparam logic signed [15:0] VAL_MAX = 16'(VALUE_INF);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ENDGAME = 3'd0;

  typedef enum logic [1:0] {
    MODE_STORE    = 2'd0,
    MODE_RETRIEVE = 2'd1,
    MODE_CLEAR    = 2'd2,
    MODE_ADVANCE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [31:0]        lock;
    logic [15:0]        move;
    logic signed [15:0] lo_val;
    logic signed [15:0] hi_val;
    logic signed [7:0]  depth;
    logic signed [7:0]  move_dep;
    logic signed [7:0]  lo_dep;
    logic signed [7:0]  hi_dep;
    logic [DATE_W-1:0]  date;
  } entry_t;

  typedef struct packed {
    logic [31:0]        lock;
    logic [15:0]        move;
    logic signed [7:0]  depth;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } req_t;

  // per-way result of the shared evaluation unit
  typedef struct packed {
    logic                      match;
    logic                      stale;
    logic signed [SCORE_W-1:0] score;
  } eval_t;

  localparam entry_t ENTRY_RESET = '{
    lock: 32'd0, move: 16'd0, lo_val: VAL_MIN, hi_val: VAL_MAX,
    depth: DEPTH_NONE, move_dep: DEPTH_NONE, lo_dep: DEPTH_NONE,
    hi_dep: DEPTH_NONE, date: '0
  };

  function automatic logic signed [15:0] clamp_value(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v < VAL_MIN) r = VAL_MIN;
    if (v > VAL_MAX) r = VAL_MAX;
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/chta_in_if.sv
// request channel of the hash table
`default_nettype none
interface chta_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [63:0]        key;
  logic [15:0]        best_move;
  logic signed [7:0]  search_depth;
  logic signed [15:0] lower_bound;
  logic signed [15:0] upper_bound;

  modport source(output valid, mode, key, best_move, search_depth, lower_bound,
                 upper_bound, input ready);
  modport sink(input valid, mode, key, best_move, search_depth, lower_bound,
               upper_bound, output ready);
endinterface
`default_nettype wire

### hw/rtl/chta_out_if.sv
// result channel of the hash table
`default_nettype none
interface chta_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [15:0]                     found_move;
  logic signed [7:0]               found_min_depth;
  logic signed [7:0]               found_max_depth;
  logic signed [15:0]              found_min_value;
  logic signed [15:0]              found_max_value;
  logic [chta_pkg::USED_W-1:0]     used_entries;

  modport source(output valid, hit, found_move, found_min_depth, found_max_depth,
                 found_min_value, found_max_value, used_entries, input ready);
  modport sink(input valid, hit, found_move, found_min_depth, found_max_depth,
               found_min_value, found_max_value, used_entries, output ready);
endinterface
`default_nettype wire

### hw/rtl/chta_way_eval.sv
// shared per-way unit: lock compare, replacement score and hit merge
`default_nettype none
module chta_way_eval (
  input  wire chta_pkg::entry_t            ent,
  input  wire chta_pkg::req_t              req,
  input  wire logic [chta_pkg::DATE_W-1:0] cur_date,
  input  wire logic                        eg,
  output chta_pkg::eval_t                  ev,
  output chta_pkg::entry_t                 merged
);
  logic [chta_pkg::DATE_W:0]   age_w;
  logic [chta_pkg::DATE_W-1:0] age;

  always_comb begin
    if (cur_date >= ent.date) begin
      age_w = {1'b0, cur_date} - {1'b0, ent.date};
    end else begin
      age_w = {1'b0, cur_date} + (chta_pkg::DATE_W+1)'(chta_pkg::DATE_COUNT)
              - {1'b0, ent.date};
    end
    age = age_w[chta_pkg::DATE_W-1:0];

    ev.match = (ent.lock == req.lock);
    ev.stale = (ent.date != cur_date);
    ev.score = $signed({2'b00, age, 8'b0}) - chta_pkg::SCORE_W'(ent.depth);

    merged      = ent;
    merged.date = cur_date;
    if (eg || req.depth > ent.depth) begin
      merged.depth = req.depth;
    end
    if (req.move != 16'd0 && (eg || req.depth >= ent.move_dep)) begin
      merged.move_dep = req.depth;
      merged.move     = req.move;
    end
    if (req.lo != chta_pkg::VAL_MIN && (eg || req.depth >= ent.lo_dep)) begin
      merged.lo_dep = req.depth;
      merged.lo_val = req.lo;
    end
    if (req.hi != chta_pkg::VAL_MAX && (eg || req.depth >= ent.hi_dep)) begin
      merged.hi_dep = req.depth;
      merged.hi_val = req.hi;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/clustered_hash_table_with_aging_unit.sv
// top level of the clustered hash table with aging replacement
`default_nettype none
// Four-way clustered hash store. The low 16 key bits select the first of four
// consecutive entries (65539 entries in one memory with one write and one
// read port, read data registered); the upper 32 key bits are the lock. One
// request beat is taken at a time: the sequencer probes the cluster one way
// at a time through a shared evaluation unit, with a read state and then a
// compare/score state per way, and a store or retrieve hit stops the probe at
// that way. A store or retrieve then passes through a write-back state (none
// on a retrieve miss) and a state that posts the result. Advance-date goes
// straight to posting its result. Clear sweeps the memory one entry per cycle
// and then posts its result. After each result the sequencer returns to idle,
// where it takes the next request beat.
// After reset the same clearing pass runs before the first request beat is
// taken; configuration writes are taken throughout.
// Each request beat yields exactly one result beat; the result sits in an
// output register until taken, and the sequencer holds while it is full.
module clustered_hash_table_with_aging_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  chta_in_if.sink                                in_ch,
  chta_out_if.source                             out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [chta_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_EV, S_WR, S_DONE
  } state_t;

  // found fields of one result
  typedef struct packed {
    logic               hit;
    logic [15:0]        move;
    logic signed [7:0]  lo_dep;
    logic signed [7:0]  hi_dep;
    logic signed [15:0] lo_val;
    logic signed [15:0] hi_val;
  } res_t;

  localparam res_t RES_NONE = '{
    hit: 1'b0, move: 16'd0, lo_dep: chta_pkg::DEPTH_NONE,
    hi_dep: chta_pkg::DEPTH_NONE, lo_val: chta_pkg::VAL_MIN,
    hi_val: chta_pkg::VAL_MAX
  };
  localparam logic [chta_pkg::WAY_W-1:0] LAST_WAY =
    chta_pkg::WAY_W'(chta_pkg::CLUSTER_WAYS - 1);
  localparam logic [chta_pkg::ADDR_W-1:0] LAST_SLOT =
    chta_pkg::ADDR_W'(chta_pkg::SLOT_COUNT - 1);

  chta_pkg::entry_t mem [chta_pkg::SLOT_COUNT];

  state_t                          state_r;
  logic                            eg_r;
  logic [chta_pkg::DATE_W-1:0]     date_r;
  logic [chta_pkg::USED_W-1:0]     used_r;
  logic [chta_pkg::ADDR_W-1:0]     clr_addr_r;
  logic                            clr_reply_r;
  chta_pkg::req_t                  req_r;
  logic                            store_r;
  logic [chta_pkg::INDEX_BITS-1:0] base_r;
  logic [chta_pkg::WAY_W-1:0]      way_r;
  logic [chta_pkg::WAY_W-1:0]      best_way_r;
  logic signed [chta_pkg::SCORE_W-1:0] top_score_r;
  logic                            best_stale_r;
  chta_pkg::entry_t                wr_ent_r;
  logic [chta_pkg::ADDR_W-1:0]     wr_addr_r;
  res_t                            res_r;
  chta_pkg::entry_t                rd_data_r;
  logic                            out_valid_r;
  res_t                            out_res_r;
  logic [chta_pkg::USED_W-1:0]     out_used_r;

  logic [chta_pkg::ADDR_W-1:0]     rd_addr;
  logic                            mem_we;
  logic [chta_pkg::ADDR_W-1:0]     mem_waddr;
  chta_pkg::entry_t                mem_wdata;
  chta_pkg::eval_t                 ev;
  chta_pkg::entry_t                merged;
  chta_pkg::entry_t                fresh;
  chta_pkg::entry_t                refreshed;
  logic                            in_fire;
  logic                            take_way;
  logic [chta_pkg::WAY_W-1:0]      win_way;
  logic                            win_stale;
  logic [chta_pkg::USED_W-1:0]     used_inc;

  chta_way_eval u_eval (
    .ent      (rd_data_r),
    .req      (req_r),
    .cur_date (date_r),
    .eg       (eg_r),
    .ev       (ev),
    .merged   (merged)
  );

  // config port, always ready, one register
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == chta_pkg::ADDR_ENDGAME) begin
      prdata = {31'd0, eg_r};
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit             = out_res_r.hit;
  assign out_ch.found_move      = out_res_r.move;
  assign out_ch.found_min_depth = out_res_r.lo_dep;
  assign out_ch.found_max_depth = out_res_r.hi_dep;
  assign out_ch.found_min_value = out_res_r.lo_val;
  assign out_ch.found_max_value = out_res_r.hi_val;
  assign out_ch.used_entries    = out_used_r;

  assign rd_addr  = chta_pkg::ADDR_W'(base_r) + chta_pkg::ADDR_W'(way_r);
  assign used_inc = (used_r == chta_pkg::USED_MAX) ? used_r : used_r + 1'b1;

  // replacement choice: first way always taken, later ways only on a strictly
  // higher score
  assign take_way  = (way_r == '0) || (ev.score > top_score_r);
  assign win_way   = take_way ? way_r : best_way_r;
  assign win_stale = take_way ? ev.stale : best_stale_r;

  // entry written on a store miss
  always_comb begin
    fresh          = chta_pkg::ENTRY_RESET;
    fresh.lock     = req_r.lock;
    fresh.date     = date_r;
    fresh.depth    = req_r.depth;
    fresh.move     = req_r.move;
    fresh.move_dep = (req_r.move != 16'd0) ? req_r.depth : chta_pkg::DEPTH_NONE;
    fresh.lo_dep   = (req_r.lo != chta_pkg::VAL_MIN) ? req_r.depth
                                                     : chta_pkg::DEPTH_NONE;
    fresh.hi_dep   = (req_r.hi != chta_pkg::VAL_MAX) ? req_r.depth
                                                     : chta_pkg::DEPTH_NONE;
    fresh.lo_val   = req_r.lo;
    fresh.hi_val   = req_r.hi;
  end

  // entry written back on a retrieve hit: only the date moves
  always_comb begin
    refreshed      = rd_data_r;
    refreshed.date = date_r;
  end

  // single write port: clearing sweep or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr_r;
    mem_wdata = wr_ent_r;
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = chta_pkg::ENTRY_RESET;
    end else if (state_r == S_WR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      eg_r        <= 1'b0;
      date_r      <= '0;
      used_r      <= '0;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      way_r       <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == chta_pkg::ADDR_ENDGAME) begin
        eg_r <= pwdata[0];
      end
      // result taken; a new one posted from S_DONE keeps it set
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_SLOT) begin
            state_r <= clr_reply_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            req_r <= '{
              lock:  in_ch.key[63:32],
              move:  in_ch.best_move,
              depth: in_ch.search_depth,
              lo:    chta_pkg::clamp_value(in_ch.lower_bound),
              hi:    chta_pkg::clamp_value(in_ch.upper_bound)
            };
            base_r      <= in_ch.key[chta_pkg::INDEX_BITS-1:0];
            store_r     <= (in_ch.mode == chta_pkg::MODE_STORE);
            way_r       <= '0;
            res_r       <= RES_NONE;
            case (in_ch.mode)
              chta_pkg::MODE_CLEAR: begin
                date_r      <= '0;
                used_r      <= '0;
                clr_addr_r  <= '0;
                clr_reply_r <= 1'b1;
                state_r     <= S_CLR;
              end
              chta_pkg::MODE_ADVANCE: begin
                date_r  <= (date_r == chta_pkg::DATE_W'(chta_pkg::DATE_COUNT - 1))
                           ? '0 : date_r + 1'b1;
                used_r  <= '0;
                state_r <= S_DONE;
              end
              default: begin
                state_r <= S_RD;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_EV;
        end
        S_EV: begin
          if (ev.match) begin
            wr_addr_r <= rd_addr;
            state_r   <= S_WR;
            if (store_r) begin
              res_r.hit <= 1'b1;
              wr_ent_r  <= merged;
              if (ev.stale) used_r <= used_inc;
            end else begin
              wr_ent_r <= refreshed;
              res_r    <= '{
                hit:    1'b1,
                move:   rd_data_r.move,
                lo_dep: rd_data_r.lo_dep,
                hi_dep: rd_data_r.hi_dep,
                lo_val: rd_data_r.lo_val,
                hi_val: rd_data_r.hi_val
              };
            end
          end else begin
            best_way_r   <= win_way;
            best_stale_r <= win_stale;
            if (take_way) top_score_r <= ev.score;
            if (way_r == LAST_WAY) begin
              if (store_r) begin
                wr_ent_r  <= fresh;
                wr_addr_r <= chta_pkg::ADDR_W'(base_r) + chta_pkg::ADDR_W'(win_way);
                if (win_stale) used_r <= used_inc;
                state_r   <= S_WR;
              end else begin
                state_r <= S_DONE;
              end
            end else begin
              way_r   <= way_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_WR: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_res_r   <= clr_reply_r ? RES_NONE : res_r;
            out_used_r  <= used_r;
            clr_reply_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // no request beat taken while sweeping or probing
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("request taken while busy");

  // advance-date zeroes the used count right away
  a_adv_zero_used: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.mode == chta_pkg::MODE_ADVANCE) |=> (used_r == '0))
    else $error("used count not cleared on date advance");

  // a posted result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("result dropped before taken");

  // the used count only moves by one per probe
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV) |=> (used_r == $past(used_r) || used_r == $past(used_r) + 1'b1))
    else $error("used count jumped");
endmodule
`default_nettype wire
